@@ hw/rtl/gda_pkg.sv @@
// Shared definitions for the Gregorian date arithmetic block.
// Field layout, calendar constants, month tables and controller/datapath interface types.
// No dependencies.
package gda_pkg;

    localparam int YEAR_SPAN = 256;
    localparam int BASE_YEAR = 2000;
    localparam int END_YEAR  = BASE_YEAR + YEAR_SPAN - 1;

    // Field widths.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int OFF_W   = 16;
    localparam int DIFF_W  = 18;

    localparam int DIFF_LIMIT = 131071;

    // Days from 1 January of year 0 to 1 January of year y.
    function automatic int days_to_year_c(input int y);
        int ym1;
        ym1 = y - 1;
        if (y == 0) begin
            return 0;
        end
        return 365 * y + ym1 / 4 - ym1 / 100 + ym1 / 400 + 1;
    endfunction

    localparam int BASE_DTY = days_to_year_c(BASE_YEAR);
    localparam int LAST_DAY = days_to_year_c(BASE_YEAR + YEAR_SPAN) - BASE_DTY - 1;

    // Day numbers of any 12-bit year, and differences of two of them.
    localparam int DTY_W = 21;
    localparam int N_W   = 22;
    // Day index within the span while the sum is walked year by year.
    localparam int T_W   = ($clog2(LAST_DAY + 1) > 9) ? $clog2(LAST_DAY + 1) : 9;
    // Sum year counter; wide enough for the last year of the span.
    localparam int SY_W  = ($clog2(END_YEAR + 1) > YEAR_W) ? $clog2(END_YEAR + 1) : YEAR_W;

    // Division by 100 of a 12-bit value as a multiply by a scaled reciprocal.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int Q_W         = YEAR_W + RECIP_W - RECIP_SHIFT;

    // Position of the base year within the 4, 100 and 400 year leap cycles.
    localparam int BASE_MOD4   = BASE_YEAR % 4;
    localparam int BASE_MOD100 = BASE_YEAR % 100;
    localparam int BASE_MOD400 = BASE_YEAR % 400;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // Input transfer layout.
    localparam int I_A_DAY   = 0;
    localparam int I_A_MONTH = I_A_DAY + DAY_W;
    localparam int I_A_YEAR  = I_A_MONTH + MONTH_W;
    localparam int I_OFF     = I_A_YEAR + YEAR_W;
    localparam int I_B_DAY   = I_OFF + OFF_W;
    localparam int I_B_MONTH = I_B_DAY + DAY_W;
    localparam int I_B_YEAR  = I_B_MONTH + MONTH_W;
    localparam int S_TDATA_W = 64;

    // Output transfer layout.
    localparam int O_DAY     = 0;
    localparam int O_MONTH   = O_DAY + DAY_W;
    localparam int O_YEAR    = O_MONTH + MONTH_W;
    localparam int O_RERR    = O_YEAR + YEAR_W;
    localparam int O_DIFF    = O_RERR + 1;
    localparam int O_GT      = O_DIFF + DIFF_W;
    localparam int O_EQ      = O_GT + 1;
    localparam int O_AV      = O_EQ + 1;
    localparam int O_BV      = O_AV + 1;
    localparam int M_TDATA_W = 48;

    // Days before the first of month m in a common year.
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
            4'd2:                                      r = leap ? 5'd29 : 5'd28;
            default:                                   r = 5'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic load;        // capture the input transfer
        logic dn_sel;      // 0: date A, 1: date B
        logic dn_s1;       // day number step 1: quotients by 100
        logic dn_s2;       // day number step 2: days to year, leap flag
        logic dn_s3;       // day number step 3: month and day added
        logic sum_init;    // offset added, saturation decided
        logic year_step;
        logic month_step;
        logic out_load;
    } gda_cmd_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } gda_status_t;

endpackage

@@ hw/rtl/gregorian_date_arithmetic.sv @@
// Gregorian date arithmetic, top level. One input transfer carries date A, a signed day
// offset and date B; one output transfer returns A plus the offset, the day number
// difference A minus B, compare flags and a validity flag per date. After acceptance,
// the two day numbers are computed in turn in a shared three-step unit, and the sum is
// then walked one year per cycle from 2000 (up to 255 steps) and one month per cycle
// (up to 11 steps). One item is in work at a time; a new item is accepted while the
// previous result still waits in the output register. Sums outside 2000..2255 saturate
// and set range_error.
// Depends on gda_pkg, gda_controller and gda_datapath.
module gregorian_date_arithmetic import gda_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: a_day, a_month, a_year, day_offset, b_day, b_month, b_year, zeros
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: sum_day, sum_month, sum_year, range_error, day_difference,
    // a_greater, a_equal, a_valid, b_valid, zeros
    output logic [M_TDATA_W-1:0] m_tdata
);

    gda_cmd_t    cmd;
    gda_status_t status;

    gda_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gda_datapath u_dp (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

@@ hw/rtl/gda_datapath.sv @@
// Datapath of the Gregorian date arithmetic block: input capture, shared day number
// unit, year and month walk of the sum, and the result register.
// Depends on gda_pkg.
module gda_datapath import gda_pkg::*; (
    input  logic                 aclk,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  gda_cmd_t             cmd,
    output gda_status_t          status,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [DAY_W-1:0]   a_day_reg, b_day_reg;
    logic [MONTH_W-1:0] a_month_reg, b_month_reg;
    logic [YEAR_W-1:0]  a_year_reg, b_year_reg;
    logic [OFF_W-1:0]   off_reg;

    // Day number unit stage registers.
    logic [YEAR_W-1:0]  s1_y_reg, s2_y_reg;
    logic [Q_W-1:0]     s1_q1_reg, s1_qy_reg;
    logic [DAY_W-1:0]   s1_d_reg, s2_d_reg;
    logic [MONTH_W-1:0] s1_m_reg, s2_m_reg;
    logic               s1_mok_reg, s2_mok_reg;
    logic [DTY_W-1:0]   s2_dty_reg;
    logic               s2_leap_reg;

    logic signed [N_W-1:0] na_reg, nb_reg;
    logic                  a_valid_reg, b_valid_reg;

    // Sum walk registers.
    logic [T_W-1:0]     t_reg;
    logic [SY_W-1:0]    sy_reg;
    logic [MONTH_W-1:0] sm_reg;
    logic [1:0]         c4_reg;
    logic [6:0]         c100_reg;
    logic [8:0]         c400_reg;
    logic               sat_reg, rerr_reg;

    logic [M_TDATA_W-1:0] out_reg;

    // Step 1 operands.
    logic [DAY_W-1:0]               op_d;
    logic [MONTH_W-1:0]             op_m, op_m_clamp;
    logic [YEAR_W-1:0]              op_y, op_ym1;
    logic [YEAR_W+RECIP_W-1:0]      prod_ym1, prod_y;

    always_comb begin
        op_d = cmd.dn_sel ? b_day_reg   : a_day_reg;
        op_m = cmd.dn_sel ? b_month_reg : a_month_reg;
        op_y = cmd.dn_sel ? b_year_reg  : a_year_reg;
        op_ym1 = op_y - YEAR_W'(1);
        if (op_m < MONTH_JAN) begin
            op_m_clamp = MONTH_JAN;
        end else if (op_m > MONTH_DEC) begin
            op_m_clamp = MONTH_DEC;
        end else begin
            op_m_clamp = op_m;
        end
    end

    assign prod_ym1 = (YEAR_W+RECIP_W)'(op_ym1) * (YEAR_W+RECIP_W)'(RECIP_100);
    assign prod_y   = (YEAR_W+RECIP_W)'(op_y)   * (YEAR_W+RECIP_W)'(RECIP_100);

    // Step 2: days to the start of the year, and the leap flag of the year.
    logic [YEAR_W-1:0] s1_ym1;
    logic [DTY_W-1:0]  dty_next;
    logic [YEAR_W:0]   qy_x100;
    logic              leap_next;

    assign s1_ym1  = s1_y_reg - YEAR_W'(1);
    assign qy_x100 = (YEAR_W+1)'(s1_qy_reg) * (YEAR_W+1)'(100);

    always_comb begin
        if (s1_y_reg == '0) begin
            dty_next = '0;
        end else begin
            dty_next = DTY_W'(365) * DTY_W'(s1_y_reg) + DTY_W'(s1_ym1 >> 2)
                     - DTY_W'(s1_q1_reg) + DTY_W'(s1_q1_reg >> 2) + DTY_W'(1);
        end
        leap_next = (s1_y_reg[1:0] == 2'b00)
                 && (({1'b0, s1_y_reg} != qy_x100) || (s1_qy_reg[1:0] == 2'b00));
    end

    // Step 3: day number relative to 1 January of the base year, and date validity.
    logic signed [N_W-1:0] n_next;
    logic                  feb_adj;
    logic                  valid_next;

    always_comb begin
        feb_adj = s2_leap_reg && (s2_m_reg > MONTH_FEB);
        n_next  = N_W'(s2_dty_reg) - N_W'(BASE_DTY) + N_W'(month_start(s2_m_reg))
                + N_W'(feb_adj) + N_W'(s2_d_reg) - N_W'(1);
        valid_next = s2_mok_reg
                  && (SY_W'(s2_y_reg) >= SY_W'(BASE_YEAR))
                  && (SY_W'(s2_y_reg) <= SY_W'(END_YEAR))
                  && (s2_d_reg != '0)
                  && (s2_d_reg <= month_len(s2_m_reg, s2_leap_reg));
    end

    // Sum walk.
    logic signed [N_W-1:0] t_full;
    logic                  sum_leap;
    logic [8:0]            ylen;
    logic [DAY_W-1:0]      sum_mlen;

    assign t_full   = na_reg + N_W'($signed(off_reg));
    assign sum_leap = (c4_reg == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen     = sum_leap ? 9'd366 : 9'd365;
    assign sum_mlen = month_len(sm_reg, sum_leap);

    assign status.year_more  = !sat_reg && (t_reg >= T_W'(ylen));
    assign status.month_more = !sat_reg && (sm_reg < MONTH_DEC) && (t_reg >= T_W'(sum_mlen));

    // Result fields.
    logic signed [N_W:0]    diff_full;
    logic [DIFF_W-1:0]      diff_sat;
    logic                   a_eq;
    logic [M_TDATA_W-1:0]   out_next;

    assign diff_full = {na_reg[N_W-1], na_reg} - {nb_reg[N_W-1], nb_reg};
    assign a_eq = (a_day_reg == b_day_reg) && (a_month_reg == b_month_reg)
               && (a_year_reg == b_year_reg);

    always_comb begin
        if (diff_full > (N_W+1)'(DIFF_LIMIT)) begin
            diff_sat = DIFF_W'(DIFF_LIMIT);
        end else if (diff_full < -(N_W+1)'(DIFF_LIMIT)) begin
            diff_sat = DIFF_W'(-DIFF_LIMIT);
        end else begin
            diff_sat = diff_full[DIFF_W-1:0];
        end
    end

    always_comb begin
        out_next = '0;
        out_next[O_DAY +: DAY_W]     = DAY_W'(t_reg) + DAY_W'(1);
        out_next[O_MONTH +: MONTH_W] = sm_reg;
        out_next[O_YEAR +: YEAR_W]   = sy_reg[YEAR_W-1:0];
        out_next[O_RERR]             = rerr_reg;
        out_next[O_DIFF +: DIFF_W]   = diff_sat;
        out_next[O_GT]               = (na_reg > nb_reg);
        out_next[O_EQ]               = a_eq;
        out_next[O_AV]               = a_valid_reg;
        out_next[O_BV]               = b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_day_reg   <= s_tdata[I_A_DAY +: DAY_W];
            a_month_reg <= s_tdata[I_A_MONTH +: MONTH_W];
            a_year_reg  <= s_tdata[I_A_YEAR +: YEAR_W];
            off_reg     <= s_tdata[I_OFF +: OFF_W];
            b_day_reg   <= s_tdata[I_B_DAY +: DAY_W];
            b_month_reg <= s_tdata[I_B_MONTH +: MONTH_W];
            b_year_reg  <= s_tdata[I_B_YEAR +: YEAR_W];
        end
        if (cmd.dn_s1) begin
            s1_y_reg   <= op_y;
            s1_q1_reg  <= prod_ym1[RECIP_SHIFT +: Q_W];
            s1_qy_reg  <= prod_y[RECIP_SHIFT +: Q_W];
            s1_d_reg   <= op_d;
            s1_m_reg   <= op_m_clamp;
            s1_mok_reg <= (op_m >= MONTH_JAN) && (op_m <= MONTH_DEC);
        end
        if (cmd.dn_s2) begin
            s2_dty_reg  <= dty_next;
            s2_leap_reg <= leap_next;
            s2_y_reg    <= s1_y_reg;
            s2_d_reg    <= s1_d_reg;
            s2_m_reg    <= s1_m_reg;
            s2_mok_reg  <= s1_mok_reg;
        end
        if (cmd.dn_s3) begin
            if (cmd.dn_sel) begin
                nb_reg      <= n_next;
                b_valid_reg <= valid_next;
            end else begin
                na_reg      <= n_next;
                a_valid_reg <= valid_next;
            end
        end
        if (cmd.sum_init) begin
            c4_reg   <= 2'(BASE_MOD4);
            c100_reg <= 7'(BASE_MOD100);
            c400_reg <= 9'(BASE_MOD400);
            if (t_full < 0) begin
                t_reg    <= '0;
                sy_reg   <= SY_W'(BASE_YEAR);
                sm_reg   <= MONTH_JAN;
                sat_reg  <= 1'b1;
                rerr_reg <= 1'b1;
            end else if (t_full > N_W'(LAST_DAY)) begin
                t_reg    <= T_W'(30);
                sy_reg   <= SY_W'(END_YEAR);
                sm_reg   <= MONTH_DEC;
                sat_reg  <= 1'b1;
                rerr_reg <= 1'b1;
            end else begin
                t_reg    <= T_W'(t_full);
                sy_reg   <= SY_W'(BASE_YEAR);
                sm_reg   <= MONTH_JAN;
                sat_reg  <= 1'b0;
                rerr_reg <= 1'b0;
            end
        end else if (cmd.year_step) begin
            t_reg    <= t_reg - T_W'(ylen);
            sy_reg   <= sy_reg + SY_W'(1);
            c4_reg   <= c4_reg + 2'd1;
            c100_reg <= (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
        end else if (cmd.month_step) begin
            t_reg  <= t_reg - T_W'(sum_mlen);
            sm_reg <= sm_reg + MONTH_W'(1);
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ hw/rtl/gda_controller.sv @@
// Controller of the Gregorian date arithmetic block: sequences the day number unit,
// the year and month walk and the result register, and runs both handshakes.
// Depends on gda_pkg.
module gda_controller import gda_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  gda_status_t status,
    output gda_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_INIT,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // The result register may be refilled in the cycle its transfer completes.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load      = 1'b1;
                    s_tready_next = 1'b0;
                    state_next    = ST_A1;
                end
            end
            ST_A1: begin
                cmd.dn_s1  = 1'b1;
                state_next = ST_A2;
            end
            ST_A2: begin
                cmd.dn_s2  = 1'b1;
                state_next = ST_A3;
            end
            ST_A3: begin
                cmd.dn_s3  = 1'b1;
                state_next = ST_B1;
            end
            ST_B1: begin
                cmd.dn_sel = 1'b1;
                cmd.dn_s1  = 1'b1;
                state_next = ST_B2;
            end
            ST_B2: begin
                cmd.dn_sel = 1'b1;
                cmd.dn_s2  = 1'b1;
                state_next = ST_B3;
            end
            ST_B3: begin
                cmd.dn_sel = 1'b1;
                cmd.dn_s3  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.sum_init = 1'b1;
                state_next   = ST_YEAR;
            end
            ST_YEAR: begin
                if (status.year_more) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (status.month_more) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    s_tready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/gda_checker.sv @@
// Port-level checker for the Gregorian date arithmetic block, bound to the top level.
// Depends on gda_pkg and gregorian_date_arithmetic.
module gda_checker import gda_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is never accepted again right after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again right after a transfer");

    // The sum is always a date with a real month and a nonzero day.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[O_MONTH +: MONTH_W] >= 4'd1
                  && m_tdata[O_MONTH +: MONTH_W] <= 4'd12
                  && m_tdata[O_DAY +: DAY_W] != 5'd0)
        else $error("sum date out of range");

    // Identical dates have no difference and neither is later.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[O_EQ] |-> m_tdata[O_DIFF +: DIFF_W] == '0 && !m_tdata[O_GT])
        else $error("equal dates with nonzero difference");

    // A saturated sum is the first or the last day of a year.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[O_RERR] |->
            (m_tdata[O_DAY +: DAY_W] == 5'd1 && m_tdata[O_MONTH +: MONTH_W] == 4'd1)
         || (m_tdata[O_DAY +: DAY_W] == 5'd31 && m_tdata[O_MONTH +: MONTH_W] == 4'd12))
        else $error("saturated sum is not a span limit");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
